// ----- hw/rtl/jsu_pkg.sv -----
// Shared types, character codes and helper functions for the JSON string unescaper.
// No dependencies; the front end, queue, back end and top level in hw/rtl refer to this package by scoped names.
package jsu_pkg;

  // Decoder mode; the fourth 2-bit code is unused and behaves as plain text.
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  localparam int RUN_MAX = 6;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_FF  = 8'h0C;

  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [15:0] CP_TWO     = 16'h0080;
  localparam logic [15:0] CP_THREE   = 16'h0800;

  // One input's worth of decoded bytes, in order from index 0.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              count;
    logic                    fin;
  } run_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- hw/rtl/jsu_if.sv -----
// Valid/ready channel interfaces for the unescaper's input and result streams.
// Depends on nothing; the top level uses one of each.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input string_end,
                  output ready);
endinterface

// ----- hw/rtl/jsu_front.sv -----
// Front end: accepts input bytes, tracks escape state and builds each byte's output run.
// Depends on jsu_pkg.
module jsu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             is_final,
  output logic             push_valid,
  output jsu_pkg::run_t    push_run,
  input  logic             push_ready
);

  jsu_pkg::mode_t   mode_r, mode_nxt;
  logic [1:0]       digits_r, digits_nxt;
  logic [11:0]      acc_r, acc_nxt;
  logic [2:0][7:0]  held_r, held_nxt;
  jsu_pkg::run_t    run;
  jsu_pkg::hex_t    hx;
  logic [15:0]      cp;
  logic             accept;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && (run.count != 3'd0);
  assign push_run   = run;

  always_comb begin
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    acc_nxt    = acc_r;
    held_nxt   = held_r;
    run        = '0;
    run.fin    = is_final;
    hx         = jsu_pkg::hex_decode(in_byte);
    cp         = {acc_r, hx.value};

    case (mode_r)
      jsu_pkg::MODE_ESC: begin
        mode_nxt  = jsu_pkg::MODE_PLAIN;
        run.count = 3'd1;
        case (in_byte)
          jsu_pkg::CH_N: run.bytes[0] = jsu_pkg::CH_LF;
          jsu_pkg::CH_R: run.bytes[0] = jsu_pkg::CH_CR;
          jsu_pkg::CH_T: run.bytes[0] = jsu_pkg::CH_TAB;
          jsu_pkg::CH_B: run.bytes[0] = jsu_pkg::CH_BS;
          jsu_pkg::CH_F: run.bytes[0] = jsu_pkg::CH_FF;
          jsu_pkg::CH_U: begin
            if (is_final) begin
              run.bytes[0] = jsu_pkg::CH_BSL;
              run.bytes[1] = jsu_pkg::CH_U;
              run.count    = 3'd2;
            end else begin
              mode_nxt   = jsu_pkg::MODE_HEX;
              digits_nxt = 2'd0;
              acc_nxt    = '0;
              run.count  = 3'd0;
            end
          end
          default: run.bytes[0] = in_byte;
        endcase
      end

      jsu_pkg::MODE_HEX: begin
        if (!hx.is_hex) begin
          // Broken escape: flush backslash, u and held digits, then handle the byte as in plain mode.
          run.bytes[0] = jsu_pkg::CH_BSL;
          run.bytes[1] = jsu_pkg::CH_U;
          run.bytes[2] = held_r[0];
          run.bytes[3] = held_r[1];
          run.bytes[4] = held_r[2];
          run.count    = 3'(digits_r) + 3'd2;
          mode_nxt     = jsu_pkg::MODE_PLAIN;
          digits_nxt   = 2'd0;
          acc_nxt      = '0;
          if (in_byte == jsu_pkg::CH_BSL && !is_final) begin
            mode_nxt = jsu_pkg::MODE_ESC;
          end else begin
            run.bytes[3'(digits_r) + 3'd2] = in_byte;
            run.count = 3'(digits_r) + 3'd3;
          end
        end else if (digits_r == 2'd3) begin
          mode_nxt   = jsu_pkg::MODE_PLAIN;
          digits_nxt = 2'd0;
          acc_nxt    = '0;
          if (cp < jsu_pkg::CP_TWO) begin
            run.bytes[0] = cp[7:0];
            run.count    = 3'd1;
          end else if (cp < jsu_pkg::CP_THREE) begin
            run.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
            run.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
            run.count    = 3'd2;
          end else begin
            run.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]};
            run.bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
            run.bytes[2] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
            run.count    = 3'd3;
          end
        end else begin
          held_nxt[digits_r] = in_byte;
          digits_nxt         = digits_r + 2'd1;
          acc_nxt            = {acc_r[7:0], hx.value};
          if (is_final) begin
            run.bytes[0] = jsu_pkg::CH_BSL;
            run.bytes[1] = jsu_pkg::CH_U;
            run.bytes[2] = held_nxt[0];
            run.bytes[3] = held_nxt[1];
            run.bytes[4] = held_nxt[2];
            run.count    = 3'(digits_r) + 3'd3;
          end
        end
      end

      default: begin
        mode_nxt = jsu_pkg::MODE_PLAIN;
        if (in_byte == jsu_pkg::CH_BSL && !is_final) begin
          mode_nxt = jsu_pkg::MODE_ESC;
        end else begin
          run.bytes[0] = in_byte;
          run.count    = 3'd1;
        end
      end
    endcase

    // String end: drop all escape state.
    if (is_final) begin
      mode_nxt   = jsu_pkg::MODE_PLAIN;
      digits_nxt = 2'd0;
      acc_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= jsu_pkg::MODE_PLAIN;
      digits_r <= 2'd0;
      acc_r    <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      digits_r <= digits_nxt;
      acc_r    <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ----- hw/rtl/jsu_queue.sv -----
// Small FIFO of decoded runs between the front end and the output serializer.
// Depends on jsu_pkg.
module jsu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  jsu_pkg::run_t push_run,
  output logic          head_valid,
  output jsu_pkg::run_t head_run,
  input  logic          pop
);

  jsu_pkg::run_t                  mem_r [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [jsu_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [jsu_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign push_ready = (cnt_r != jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_run   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

// ----- hw/rtl/jsu_back.sv -----
// Back end: walks the head run one byte per cycle, while the receiver is ready, into a registered result word.
// Depends on jsu_pkg.
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  jsu_pkg::run_t head_run,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          run_end,
  output logic          string_end
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       run_end_r, string_end_r;
  logic       load, last;

  assign load = head_valid && (!valid_r || out_ready);
  assign last = (idx_r == head_run.count - 3'd1);
  assign pop  = load && last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = last ? 3'd0 : idx_r + 3'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r       <= head_run.bytes[idx_r];
      run_end_r    <= last;
      string_end_r <= last && head_run.fin;
    end
  end

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign run_end    = run_end_r;
  assign string_end = string_end_r;

endmodule

// ----- hw/rtl/json_string_unescape.sv -----
// Top level of the JSON string body unescaper (escapes and \u to UTF-8).
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   in_ch    | in  | valid/ready        | in_byte[7:0], is_final
//   out_ch   | out | valid/ready        | out_byte[7:0], run_end, string_end
//
// Rates: one input word per cycle while the run queue has room; each input
// makes 0 to 6 result words, and the back end sends one result word per cycle
// while the receiver is ready.
// Reset: rst_n is synchronous, active low; it returns the decoder to plain text
// and empties the queue and output register. No clearing pass is needed.
// Stalls: a 4-entry run queue separates front and back, so input is taken while
// a result waits; in_ch.ready falls only when the queue is full.
module json_string_unescape (
  input  logic             clk,
  input  logic             rst_n,
  jsu_in_if.sink           in_ch,
  jsu_out_if.source        out_ch
);

  // Front to queue: one decoded run per accepted input that produces output.
  logic          push_valid;
  logic          push_ready;
  jsu_pkg::run_t push_run;

  // Queue to back: head run and pop when its last byte is loaded.
  logic          head_valid;
  jsu_pkg::run_t head_run;
  logic          pop;

  // Classify each byte and build its output run.
  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .is_final   (in_ch.is_final),
    .push_valid (push_valid),
    .push_run   (push_run),
    .push_ready (push_ready)
  );

  // Hold runs until the serializer drains them.
  jsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_run   (push_run),
    .head_valid (head_valid),
    .head_run   (head_run),
    .pop        (pop)
  );

  // Advance through the head run one word per cycle while the receiver is ready.
  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_run   (head_run),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .run_end    (out_ch.run_end),
    .string_end (out_ch.string_end)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for json_string_unescape: escaped string bytes in, decoded words out.
// Depends on jsu_pkg (mode codes, character and UTF-8 constants) and jsu_if (channels).
// A scoreboard class predicts every decoded word; random pacing exercises both handshakes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam int SETTLE_CYCLES = 16;   // a few times the run queue depth
  localparam int HOLD_CYCLES   = 80;   // long receiver hold-off

  // Predicts the decoded words of each accepted input word and checks them in order.
  class unescape_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       string_end;
    } decoded_word_t;

    jsu_pkg::mode_t  mode;
    logic [1:0]      digit_count;
    logic [7:0]      digit_chars [3];
    logic [15:0]     code_acc;
    logic [7:0]      run_bytes [$];
    decoded_word_t   decoded_q [$];
    int              errors;

    function new();
      clear_escape();
      errors = 0;
    endfunction

    static function int hex_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
      return -1;
    endfunction

    function void clear_escape();
      mode = jsu_pkg::MODE_PLAIN;
      digit_count = 2'd0;
      code_acc = 16'h0000;
    endfunction

    // Emit an unfinished \u escape as backslash, u and the digits seen.
    function void flush_partial();
      run_bytes.push_back(jsu_pkg::CH_BSL);
      run_bytes.push_back(jsu_pkg::CH_U);
      for (int k = 0; k < digit_count; k++) run_bytes.push_back(digit_chars[k]);
      clear_escape();
    endfunction

    function void take_plain(input logic [7:0] c, input logic fin);
      if (c == jsu_pkg::CH_BSL) begin
        if (fin) run_bytes.push_back(jsu_pkg::CH_BSL);
        else mode = jsu_pkg::MODE_ESC;
      end else begin
        run_bytes.push_back(c);
      end
    endfunction

    function void take_escaped_byte(input logic [7:0] c, input logic fin);
      int          v;
      logic [15:0] cp;
      logic        last;
      run_bytes.delete();
      case (mode)
        jsu_pkg::MODE_ESC: begin
          mode = jsu_pkg::MODE_PLAIN;
          case (c)
            jsu_pkg::CH_N: run_bytes.push_back(jsu_pkg::CH_LF);
            jsu_pkg::CH_R: run_bytes.push_back(jsu_pkg::CH_CR);
            jsu_pkg::CH_T: run_bytes.push_back(jsu_pkg::CH_TAB);
            jsu_pkg::CH_B: run_bytes.push_back(jsu_pkg::CH_BS);
            jsu_pkg::CH_F: run_bytes.push_back(jsu_pkg::CH_FF);
            jsu_pkg::CH_U: begin
              if (fin) begin
                run_bytes.push_back(jsu_pkg::CH_BSL);
                run_bytes.push_back(jsu_pkg::CH_U);
              end else begin
                mode = jsu_pkg::MODE_HEX;
                digit_count = 2'd0;
                code_acc = 16'h0000;
              end
            end
            default: run_bytes.push_back(c);
          endcase
        end
        jsu_pkg::MODE_HEX: begin
          v = hex_value(c);
          if (v < 0) begin
            flush_partial();
            take_plain(c, fin);
          end else if (digit_count == 2'd3) begin
            cp = {code_acc[11:0], v[3:0]};
            clear_escape();
            if (cp < jsu_pkg::CP_TWO) begin
              run_bytes.push_back(cp[7:0]);
            end else if (cp < jsu_pkg::CP_THREE) begin
              run_bytes.push_back(jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]});
              run_bytes.push_back(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]});
            end else begin
              run_bytes.push_back(jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]});
              run_bytes.push_back(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]});
              run_bytes.push_back(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]});
            end
          end else begin
            digit_chars[digit_count] = c;
            digit_count++;
            code_acc = {code_acc[11:0], v[3:0]};
            if (fin) flush_partial();
          end
        end
        default: begin
          mode = jsu_pkg::MODE_PLAIN;
          take_plain(c, fin);
        end
      endcase
      if (fin) clear_escape();
      foreach (run_bytes[k]) begin
        last = (k == run_bytes.size() - 1);
        decoded_q.push_back('{run_bytes[k], last, last && fin});
      end
    endfunction

    function void check_decoded_word(input logic [7:0] data, input logic re, input logic se);
      decoded_word_t w;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte=%02h run_end=%0b string_end=%0b",
                 $time, data, re, se);
        errors++;
        return;
      end
      w = decoded_q.pop_front();
      if (data !== w.data || re !== w.run_end || se !== w.string_end) begin
        $display("%0t: word mismatch: expected byte=%02h run_end=%0b string_end=%0b, %s",
                 $time, w.data, w.run_end, w.string_end,
                 $sformatf("actual byte=%02h run_end=%0b string_end=%0b", data, re, se));
        errors++;
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  unescape_scoreboard sb = new();

  logic       tx_gaps_on   = 1'b0;
  logic       rx_stalls_on = 1'b0;
  int         rx_hold_cycles = 0;
  int         words_sent = 0;
  logic [7:0] text_q [$];     // bytes of the string being built

  // Check every word the receiver takes; ready and valid read here are pre-edge values.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_decoded_word(out_ch.out_byte, out_ch.run_end, out_ch.string_end);
  end

  // Receiver pacing: hold off for a long stretch on request, else stall in random bursts.
  initial begin : rx_pacing
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one word and return once it is accepted. Valid stays high on return so that
  // a following word goes out back to back; lower it before any wait.
  task automatic send_word(input logic [7:0] b, input logic fin);
    int n;
    if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= b;
    in_ch.is_final <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_escaped_byte(b, fin);
    words_sent++;
  endtask

  // Send the built string, flag its last byte as final, and clear it.
  task automatic send_text();
    foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Drop valid and hold until every predicted word has come out, then let the pipe settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  function automatic void append_unicode(input logic [15:0] cp);
    text_q.push_back(jsu_pkg::CH_BSL);
    text_q.push_back(jsu_pkg::CH_U);
    for (int s = 3; s >= 0; s--) text_q.push_back(hex_char(cp[s*4 +: 4]));
  endfunction

  // Build a string of random plain bytes and well-formed escapes, mixed with noise:
  // stray backslashes, broken \u escapes and strings cut off inside an escape.
  function automatic void build_random_text(input int n_tokens);
    logic [7:0] esc_letters [8];
    logic [7:0] b;
    logic [15:0] cp;
    int kind;
    esc_letters = '{jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_B,
                    jsu_pkg::CH_F, CH_QUOTE, jsu_pkg::CH_BSL, CH_SLASH};
    for (int t = 0; t < n_tokens; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 60) begin
        text_q.push_back(jsu_pkg::CH_BSL);
        if ($urandom_range(0, 3) == 0) text_q.push_back(8'($urandom_range(0, 255)));
        else text_q.push_back(esc_letters[$urandom_range(0, 7)]);
      end else if (kind < 85) begin
        case ($urandom_range(0, 3))
          0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
          1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
          2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
          default: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
        endcase
        append_unicode(cp);
      end else if (kind < 95) begin
        // broken \u: up to three digits, then a byte that is not hex
        text_q.push_back(jsu_pkg::CH_BSL);
        text_q.push_back(jsu_pkg::CH_U);
        repeat ($urandom_range(0, 3)) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        do b = 8'($urandom_range(0, 255));
        while (unescape_scoreboard::hex_value(b) >= 0);
        text_q.push_back(b);
      end else begin
        text_q.push_back(jsu_pkg::CH_BSL);
      end
    end
    // now and then end the string early, possibly inside an escape
    if (text_q.size() > 1 && $urandom_range(0, 5) == 0)
      text_q = text_q[0 : $urandom_range(0, text_q.size() - 2)];
  endfunction

  task automatic random_phase(input int target);
    while (words_sent < target) begin
      build_random_text($urandom_range(1, 8));
      send_text();
    end
  endtask

  initial begin : stimulus
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    in_ch.is_final <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: simple escapes and an escaped byte with no special meaning.
    rx_stalls_on = 1'b1;
    text_q = '{jsu_pkg::CH_BSL, jsu_pkg::CH_N, jsu_pkg::CH_BSL, jsu_pkg::CH_R,
               jsu_pkg::CH_BSL, jsu_pkg::CH_T, jsu_pkg::CH_BSL, jsu_pkg::CH_B,
               jsu_pkg::CH_BSL, jsu_pkg::CH_F, jsu_pkg::CH_BSL, 8'hFF};
    send_text();
    // Two-byte UTF-8 at its upper bound.
    append_unicode(16'h07FF);
    send_text();
    // Broken \u: a non-hex byte after one digit, and it is the final byte.
    text_q = '{jsu_pkg::CH_BSL, jsu_pkg::CH_U, 8'h31, 8'h47};
    send_text();
    // String ends inside \u, after one digit and right after the u.
    text_q = '{jsu_pkg::CH_BSL, jsu_pkg::CH_U, 8'h46};
    send_text();
    text_q = '{jsu_pkg::CH_BSL, jsu_pkg::CH_U};
    send_text();
    // NUL byte, then a lone trailing backslash.
    text_q = '{8'h00, jsu_pkg::CH_BSL};
    send_text();

    // Random traffic with idling on both sides.
    tx_gaps_on = 1'b1;
    random_phase(230);

    // Pause the sender until all words are out, then hold the receiver off while
    // the sender streams plain bytes, so the run queue fills and input stalls.
    wait_drained();
    tx_gaps_on = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 20; i++) begin
      text_q.push_back(8'($urandom_range(0, 255)));
      if (text_q[i] == jsu_pkg::CH_BSL) text_q[i] = 8'h41;
    end
    send_text();
    wait_drained();

    tx_gaps_on = 1'b1;
    random_phase(420);

    // Last stretch at full rate, no idling on either side.
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    random_phase(530);

    wait_drained();
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
